// ===== src/pst_pkg.sv =====
`default_nettype none

package pst_pkg;

	localparam int NUM_SLOTS_DEF = 8;

	localparam logic signed [3:0] ANY_CHILD = -4'sd1;
	localparam logic signed [3:0] REPLY_ERR = -4'sd1;

	typedef enum logic [2:0] {
		ACT_TICK   = 3'd0,
		ACT_FORK   = 3'd1,
		ACT_EXIT   = 3'd2,
		ACT_WAIT   = 3'd3,
		ACT_GETPID = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		ST_READY      = 2'd0,
		ST_RUNNING    = 2'd1,
		ST_BLOCKED    = 2'd2,
		ST_TERMINATED = 2'd3
	} slot_state_t;

	typedef enum logic [1:0] {
		AW_NONE = 2'd0,
		AW_ANY  = 2'd1,
		AW_ID   = 2'd2
	} await_kind_t;

	typedef struct packed {
		logic [2:0]        action;
		logic signed [3:0] wait_target;
	} pst_in_t;

	typedef struct packed {
		logic [2:0]        running_id;
		logic              switched;
		logic              reply_valid;
		logic signed [3:0] reply_value;
		logic              wake_valid;
		logic [2:0]        wake_id;
		logic [2:0]        wake_value;
		logic              deadlock;
	} pst_out_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CAPTURE,
		OP_FORK_STEP,
		OP_EXIT_RD,
		OP_EXIT_WAKE,
		OP_EXIT_CLR,
		OP_WAIT_INIT,
		OP_WAIT_STEP,
		OP_WAIT_REAP,
		OP_WAIT_BLOCK,
		OP_BAD_REPLY,
		OP_GETPID,
		OP_SCHED_CUR,
		OP_SCHED_STEP,
		OP_SCHED_DEMOTE,
		OP_LOAD_OUT
	} dp_op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_FORK,
		S_EXIT_RD,
		S_EXIT_WAKE,
		S_EXIT_CLR,
		S_WAIT_STEP,
		S_WAIT_REAP,
		S_WAIT_BLOCK,
		S_SCHED_CUR,
		S_SCHED_STEP,
		S_SCHED_DEMOTE,
		S_FINISH
	} ctl_state_t;

	typedef struct packed {
		logic [2:0] act;
		logic       tgt_any;
		logic       tgt_ok;
		logic       hit;
		logic       term;
		logic       last;
		logic       cur_run;
	} dp_status_t;

endpackage

`default_nettype wire

// ===== src/pst_datapath.sv =====
`default_nettype none

module pst_datapath #(
	parameter int NUM_SLOTS = pst_pkg::NUM_SLOTS_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  pst_pkg::pst_in_t    in_data,
	input  pst_pkg::dp_op_t     op,
	output pst_pkg::dp_status_t status,
	output pst_pkg::pst_out_t   out_data
);
	import pst_pkg::*;

	localparam int IDW = $clog2(NUM_SLOTS);
	localparam int LCW = $clog2(NUM_SLOTS + 1);
	localparam logic [IDW-1:0] LAST_ID = IDW'(NUM_SLOTS - 1);

	// slot table
	slot_state_t st_q     [NUM_SLOTS];
	logic        pv_q     [NUM_SLOTS];
	logic [IDW-1:0] pid_q [NUM_SLOTS];
	await_kind_t awk_q    [NUM_SLOTS];
	logic [IDW-1:0] awid_q [NUM_SLOTS];

	logic [IDW-1:0] cur_q;
	logic [LCW-1:0] live_q;

	logic [2:0]        act_q;
	logic signed [3:0] tgt_q;
	logic [IDW-1:0]    before_q;
	logic [IDW-1:0]    idx_q;
	logic [IDW-1:0]    tmp_q;
	logic              tmp_vld_q;
	logic              scan_one_q;
	logic              cur_run_q;
	logic              wake_hit_q;
	logic              reply_vld_q;
	logic signed [3:0] reply_val_q;
	logic [IDW-1:0]    wake_id_q;
	logic [IDW-1:0]    wake_val_q;
	pst_out_t          out_q;

	logic [IDW-1:0] addr;
	slot_state_t    st_rd;
	logic           pv_rd;
	logic [IDW-1:0] pid_rd;
	await_kind_t    awk_rd;
	logic [IDW-1:0] awid_rd;

	logic           fork_hit, wake, par_match, sched_hit, at_end, tgt_any, tgt_ok;
	logic [IDW-1:0] idx_nxt, cur_nxt, tgt_idx;
	logic [IDW+2:0] tgt_ext, idx_ext4, cur_ext4, cur_ext3, wid_ext3, wval_ext3;

	logic        st_we, par_set, par_clr, aw_set, aw_clr;
	slot_state_t st_wd;
	logic        live_old, live_new;

	always_comb begin
		case (op)
			OP_EXIT_WAKE: addr = tmp_q;
			OP_FORK_STEP,
			OP_WAIT_STEP,
			OP_SCHED_STEP: addr = idx_q;
			default: addr = cur_q;
		endcase
	end

	assign st_rd   = st_q[addr];
	assign pv_rd   = pv_q[addr];
	assign pid_rd  = pid_q[addr];
	assign awk_rd  = awk_q[addr];
	assign awid_rd = awid_q[addr];

	assign at_end    = (idx_q == LAST_ID);
	assign idx_nxt   = at_end ? '0 : idx_q + IDW'(1);
	assign cur_nxt   = (cur_q == LAST_ID) ? '0 : cur_q + IDW'(1);
	assign fork_hit  = (st_rd == ST_TERMINATED);
	assign sched_hit = (st_rd == ST_READY);
	assign par_match = pv_rd && (pid_rd == cur_q);
	assign wake      = tmp_vld_q &&
		(awk_rd == AW_ANY || (awk_rd == AW_ID && awid_rd == cur_q));

	assign tgt_any = (tgt_q == ANY_CHILD);
	assign tgt_ok  = !tgt_q[3] && (int'(tgt_q[2:0]) < NUM_SLOTS);
	assign tgt_ext = {{IDW{1'b0}}, tgt_q[2:0]};
	assign tgt_idx = tgt_ext[IDW-1:0];

	// ids masked to the result field widths
	assign idx_ext4  = {3'b000, idx_q};
	assign cur_ext4  = {3'b000, cur_q};
	assign cur_ext3  = {3'b000, cur_q};
	assign wid_ext3  = {3'b000, wake_id_q};
	assign wval_ext3 = {3'b000, wake_val_q};

	always_comb begin
		status.act     = act_q;
		status.tgt_any = tgt_any;
		status.tgt_ok  = tgt_ok;
		status.term    = (st_rd == ST_TERMINATED);
		status.cur_run = cur_run_q;
		status.hit     = 1'b0;
		status.last    = 1'b0;
		case (op)
			OP_FORK_STEP: begin
				status.hit  = fork_hit;
				status.last = at_end;
			end
			OP_WAIT_STEP: begin
				status.hit  = par_match;
				status.last = scan_one_q || at_end;
			end
			OP_SCHED_CUR: status.hit = sched_hit;
			OP_SCHED_STEP: begin
				status.hit  = sched_hit;
				status.last = (idx_nxt == cur_q);
			end
			default: ;
		endcase
	end

	always_comb begin
		st_we   = 1'b0;
		st_wd   = ST_READY;
		par_set = 1'b0;
		par_clr = 1'b0;
		aw_set  = 1'b0;
		aw_clr  = 1'b0;
		case (op)
			OP_FORK_STEP: begin
				st_we   = fork_hit;
				par_set = fork_hit;
			end
			OP_EXIT_WAKE: begin
				st_we  = wake;
				aw_clr = wake;
			end
			OP_EXIT_CLR: begin
				st_we   = 1'b1;
				st_wd   = ST_TERMINATED;
				par_clr = wake_hit_q;
			end
			OP_WAIT_STEP: par_clr = par_match && (st_rd == ST_TERMINATED);
			OP_WAIT_REAP: aw_clr = 1'b1;
			OP_WAIT_BLOCK: begin
				st_we  = 1'b1;
				st_wd  = ST_BLOCKED;
				aw_set = 1'b1;
			end
			OP_SCHED_CUR,
			OP_SCHED_STEP: begin
				st_we = sched_hit;
				st_wd = ST_RUNNING;
			end
			OP_SCHED_DEMOTE: st_we = 1'b1;
			default: ;
		endcase
	end

	assign live_old = (st_rd == ST_READY) || (st_rd == ST_RUNNING);
	assign live_new = (st_wd == ST_READY) || (st_wd == ST_RUNNING);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				st_q[i]   <= (i == 0) ? ST_READY : ST_TERMINATED;
				pv_q[i]   <= 1'b0;
				pid_q[i]  <= '0;
				awk_q[i]  <= AW_NONE;
				awid_q[i] <= '0;
			end
			cur_q  <= '0;
			live_q <= LCW'(1);
		end else begin
			if (st_we) begin
				st_q[addr] <= st_wd;
				live_q <= live_q + {{(LCW-1){1'b0}}, live_new}
					- {{(LCW-1){1'b0}}, live_old};
			end
			if (par_set) begin
				pv_q[addr]  <= 1'b1;
				pid_q[addr] <= cur_q;
			end else if (par_clr) begin
				pv_q[addr] <= 1'b0;
			end
			if (aw_set) begin
				awk_q[addr]  <= tgt_any ? AW_ANY : AW_ID;
				awid_q[addr] <= tgt_idx;
			end else if (aw_clr) begin
				awk_q[addr] <= AW_NONE;
			end
			if (op == OP_SCHED_STEP && sched_hit && !cur_run_q)
				cur_q <= idx_q;
			else if (op == OP_SCHED_DEMOTE)
				cur_q <= tmp_q;
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_CAPTURE: begin
				act_q       <= in_data.action;
				tgt_q       <= in_data.wait_target;
				before_q    <= cur_q;
				idx_q       <= '0;
				reply_vld_q <= 1'b0;
				reply_val_q <= '0;
				wake_hit_q  <= 1'b0;
				wake_id_q   <= '0;
				wake_val_q  <= '0;
			end
			OP_FORK_STEP: begin
				if (fork_hit) begin
					reply_vld_q <= 1'b1;
					reply_val_q <= idx_ext4[3:0];
				end else if (at_end) begin
					reply_vld_q <= 1'b1;
					reply_val_q <= REPLY_ERR;
				end else begin
					idx_q <= idx_nxt;
				end
			end
			OP_EXIT_RD: begin
				tmp_q     <= pid_rd;
				tmp_vld_q <= pv_rd;
			end
			OP_EXIT_WAKE: begin
				if (wake) begin
					wake_hit_q <= 1'b1;
					wake_id_q  <= tmp_q;
					wake_val_q <= cur_q;
				end
			end
			OP_WAIT_INIT: begin
				idx_q      <= tgt_any ? IDW'(1) : tgt_idx;
				scan_one_q <= !tgt_any;
			end
			OP_WAIT_STEP: begin
				if (par_match) begin
					if (st_rd == ST_TERMINATED) begin
						reply_vld_q <= 1'b1;
						reply_val_q <= idx_ext4[3:0];
					end
				end else if (scan_one_q || at_end) begin
					reply_vld_q <= 1'b1;
					reply_val_q <= REPLY_ERR;
				end else begin
					idx_q <= idx_nxt;
				end
			end
			OP_BAD_REPLY: begin
				reply_vld_q <= 1'b1;
				reply_val_q <= REPLY_ERR;
			end
			OP_GETPID: begin
				reply_vld_q <= 1'b1;
				reply_val_q <= cur_ext4[3:0];
			end
			OP_SCHED_CUR: begin
				cur_run_q <= (st_rd == ST_RUNNING);
				idx_q     <= cur_nxt;
			end
			OP_SCHED_STEP: begin
				if (sched_hit)
					tmp_q <= idx_q;
				else
					idx_q <= idx_nxt;
			end
			OP_LOAD_OUT: begin
				out_q.running_id  <= cur_ext3[2:0];
				out_q.switched    <= (cur_q != before_q);
				out_q.reply_valid <= reply_vld_q;
				out_q.reply_value <= reply_val_q;
				out_q.wake_valid  <= wake_hit_q;
				out_q.wake_id     <= wid_ext3[2:0];
				out_q.wake_value  <= wval_ext3[2:0];
				out_q.deadlock    <= (live_q == '0);
			end
			default: ;
		endcase
	end

	assign out_data = out_q;

	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(live_q) <= NUM_SLOTS)
		else $error("live slot count exceeds table size");

	a_demote_new_running: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_SCHED_DEMOTE) |=> (st_q[cur_q] == ST_RUNNING))
		else $error("switched-in slot is not running");

endmodule

`default_nettype wire

// ===== src/pst_ctrl.sv =====
`default_nettype none

module pst_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire                 out_ready,
	input  pst_pkg::dp_status_t status,
	output pst_pkg::dp_op_t     op
);
	import pst_pkg::*;

	ctl_state_t state_q, state_nxt;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: if (in_valid) state_nxt = S_DISPATCH;
			S_DISPATCH: begin
				case (status.act)
					ACT_TICK: state_nxt = S_SCHED_CUR;
					ACT_FORK: state_nxt = S_FORK;
					ACT_EXIT: state_nxt = S_EXIT_RD;
					ACT_WAIT: state_nxt = (status.tgt_any || status.tgt_ok) ?
						S_WAIT_STEP : S_FINISH;
					default: state_nxt = S_FINISH;
				endcase
			end
			S_FORK: if (status.hit || status.last) state_nxt = S_FINISH;
			S_EXIT_RD: state_nxt = S_EXIT_WAKE;
			S_EXIT_WAKE: state_nxt = S_EXIT_CLR;
			S_EXIT_CLR: state_nxt = S_SCHED_CUR;
			S_WAIT_STEP: begin
				if (status.hit)
					state_nxt = status.term ? S_WAIT_REAP : S_WAIT_BLOCK;
				else if (status.last)
					state_nxt = S_FINISH;
			end
			S_WAIT_REAP: state_nxt = S_FINISH;
			S_WAIT_BLOCK: state_nxt = S_SCHED_CUR;
			S_SCHED_CUR: state_nxt = status.hit ? S_FINISH : S_SCHED_STEP;
			S_SCHED_STEP: begin
				if (status.hit)
					state_nxt = status.cur_run ? S_SCHED_DEMOTE : S_FINISH;
				else if (status.last)
					state_nxt = S_FINISH;
			end
			S_SCHED_DEMOTE: state_nxt = S_FINISH;
			S_FINISH: if (out_free) state_nxt = S_IDLE;
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		op       = OP_NONE;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) op = OP_CAPTURE;
			end
			S_DISPATCH: begin
				case (status.act)
					ACT_WAIT: op = (status.tgt_any || status.tgt_ok) ?
						OP_WAIT_INIT : OP_BAD_REPLY;
					ACT_GETPID: op = OP_GETPID;
					default: op = OP_NONE;
				endcase
			end
			S_FORK: op = OP_FORK_STEP;
			S_EXIT_RD: op = OP_EXIT_RD;
			S_EXIT_WAKE: op = OP_EXIT_WAKE;
			S_EXIT_CLR: op = OP_EXIT_CLR;
			S_WAIT_STEP: op = OP_WAIT_STEP;
			S_WAIT_REAP: op = OP_WAIT_REAP;
			S_WAIT_BLOCK: op = OP_WAIT_BLOCK;
			S_SCHED_CUR: op = OP_SCHED_CUR;
			S_SCHED_STEP: op = OP_SCHED_STEP;
			S_SCHED_DEMOTE: op = OP_SCHED_DEMOTE;
			S_FINISH: if (out_free) op = OP_LOAD_OUT;
			default: op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			// hold the result until the downstream transaction completes
			if (state_q == S_FINISH && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_finish_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH && out_free) |=> (out_valid_q && state_q == S_IDLE))
		else $error("finished result not presented");

	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_DISPATCH))
		else $error("accepted transaction not dispatched");

endmodule

`default_nettype wire

// ===== src/process_table_scheduler_unit.sv =====
// Process table with round-robin scheduler.
// Input channel (in_valid/in_ready/in_data) carries one action per
// transaction: tick, fork, exit, wait for child or get id, on behalf of the
// current slot. Output channel (out_valid/out_ready/out_data) returns exactly
// one result per action: running slot, switch flag, reply, wake report and
// deadlock flag.
// Actions run one at a time. The slot table has a single access port, so
// every scan visits one slot per cycle. The quickest actions are get id, a
// bad wait target and an unknown action; the longest is a wait for any child
// that finds a live child in the last slot, blocks, and is followed by a
// full scheduler scan. in_ready rises together with out_valid, so the next
// action is accepted in the cycle after the result is registered at the
// earliest.
// The result sits in an output register; a new action is accepted while it
// waits, and a stalled receiver only holds the next result in its final
// step until the register frees up.
// Reset (arst_n low, asynchronous) makes slot 0 ready and current, all other
// slots terminated, no parents and no waits, and empties the output register.
`default_nettype none

module process_table_scheduler_unit #(
	parameter int NUM_SLOTS = pst_pkg::NUM_SLOTS_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  pst_pkg::pst_in_t  in_data,
	output logic              out_valid,
	input  wire               out_ready,
	output pst_pkg::pst_out_t out_data
);
	import pst_pkg::*;

	dp_op_t     op;
	dp_status_t status;

	pst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.op        (op)
	);

	pst_datapath #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.op       (op),
		.status   (status),
		.out_data (out_data)
	);

endmodule

`default_nettype wire

// ===== tb/sv/process_table_scheduler_unit_tb.sv =====
`timescale 1ns / 1ps

module process_table_scheduler_unit_tb;
	import pst_pkg::*;

	localparam int SLOTS = NUM_SLOTS_DEF;
	localparam int RANDOM_ACTIONS = 1850;
	localparam logic signed [3:0] NOT_WAITING = -4'sd2;
	localparam logic signed [3:0] NO_PARENT = -4'sd1;
	localparam logic [2:0] ACT_RSVD_FIRST = 3'd5;
	localparam logic [2:0] ACT_RSVD_LAST = 3'd7;

	typedef struct {
		pst_in_t  item;
		bit       typed;
		pst_out_t want;
	} plan_row_t;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     in_valid;
	logic     in_ready;
	pst_in_t  in_data;
	logic     out_valid;
	logic     out_ready;
	pst_out_t out_data;

	slot_state_t       tbl_state [SLOTS];
	logic signed [3:0] tbl_parent [SLOTS];
	logic signed [3:0] tbl_awaited [SLOTS];
	logic [2:0]        tbl_cur;

	pst_out_t  due_results[$];
	plan_row_t directed_plan[$];
	bit        steady;
	int        mismatches;

	process_table_scheduler_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= 40) begin
			$display("MISMATCH at %0t: %s", $realtime, what);
		end
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want) begin
			report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
		end
	endtask

	// Round-robin pick; keep the current slot when nothing else is ready.
	function automatic void schedule_next();
		logic [2:0] origin;
		int         c;
		bit         found;
		origin = tbl_cur;
		found = 1'b0;
		if (tbl_state[origin] == ST_READY) begin
			tbl_state[origin] = ST_RUNNING;
			return;
		end
		for (int k = 1; k < SLOTS; k++) begin
			c = (int'(origin) + k) % SLOTS;
			if (!found && tbl_state[c] == ST_READY) begin
				found = 1'b1;
				if (tbl_state[origin] == ST_RUNNING) begin
					tbl_state[origin] = ST_READY;
				end
				tbl_state[c] = ST_RUNNING;
				tbl_cur = c[2:0];
			end
		end
	endfunction

	function automatic pst_out_t step_table(input pst_in_t a);
		pst_out_t          r;
		logic [2:0]        prev;
		logic signed [3:0] me;
		logic signed [3:0] p;
		logic signed [3:0] tgt;
		int                child;
		bit                alive;
		r = '0;
		prev = tbl_cur;
		me = {1'b0, tbl_cur};
		tgt = $signed(a.wait_target);
		child = -1;
		alive = 1'b0;
		case (a.action)
			ACT_TICK: begin
				schedule_next();
			end
			ACT_FORK: begin
				r.reply_valid = 1'b1;
				r.reply_value = REPLY_ERR;
				for (int i = 0; i < SLOTS; i++) begin
					if (child < 0 && tbl_state[i] == ST_TERMINATED) begin
						child = i;
						tbl_parent[i] = me;
						tbl_state[i] = ST_READY;
						r.reply_value = 4'(i);
					end
				end
			end
			ACT_EXIT: begin
				p = tbl_parent[tbl_cur];
				if (p >= 0) begin
					if (tbl_awaited[p[2:0]] == me || tbl_awaited[p[2:0]] == ANY_CHILD) begin
						tbl_awaited[p[2:0]] = NOT_WAITING;
						tbl_state[p[2:0]] = ST_READY;
						tbl_parent[tbl_cur] = NO_PARENT;
						r.wake_valid = 1'b1;
						r.wake_id = p[2:0];
						r.wake_value = tbl_cur;
					end
				end
				tbl_state[tbl_cur] = ST_TERMINATED;
				schedule_next();
			end
			ACT_WAIT: begin
				if (tgt == ANY_CHILD) begin
					for (int i = 1; i < SLOTS; i++) begin
						if (child < 0 && tbl_parent[i] == me) begin
							child = i;
						end
					end
				end else if (tgt >= 0 && tbl_parent[tgt[2:0]] == me) begin
					child = int'(tgt);
				end
				if (child < 0) begin
					r.reply_valid = 1'b1;
					r.reply_value = REPLY_ERR;
				end else if (tbl_state[child] == ST_TERMINATED) begin
					r.reply_valid = 1'b1;
					r.reply_value = 4'(child);
					tbl_awaited[tbl_cur] = NOT_WAITING;
					tbl_parent[child] = NO_PARENT;
				end else begin
					tbl_state[tbl_cur] = ST_BLOCKED;
					tbl_awaited[tbl_cur] = tgt;
					schedule_next();
				end
			end
			ACT_GETPID: begin
				r.reply_valid = 1'b1;
				r.reply_value = me;
			end
			default: ;
		endcase
		for (int i = 0; i < SLOTS; i++) begin
			if (tbl_state[i] == ST_READY || tbl_state[i] == ST_RUNNING) begin
				alive = 1'b1;
			end
		end
		r.running_id = tbl_cur;
		r.switched = (tbl_cur != prev);
		r.deadlock = !alive;
		return r;
	endfunction

	function automatic pst_out_t plain_out(input logic [2:0] run, input logic rv,
		input logic signed [3:0] val);
		pst_out_t r;
		r = '0;
		r.running_id = run;
		r.reply_valid = rv;
		r.reply_value = val;
		return r;
	endfunction

	function automatic void plan(input logic [2:0] act, input logic signed [3:0] tgt,
		input bit typed, input pst_out_t want);
		plan_row_t row;
		row.item.action = act;
		row.item.wait_target = tgt;
		row.typed = typed;
		row.want = want;
		directed_plan.push_back(row);
	endfunction

	// Pick a wait target: mostly any child or a real child of the caller.
	function automatic logic signed [3:0] pick_target();
		int roll;
		int start;
		int c;
		logic signed [3:0] t;
		roll = $urandom_range(0, 99);
		t = ANY_CHILD;
		if (roll >= 88) begin
			t = 4'($urandom_range(0, 15));
		end else if (roll >= 55) begin
			start = $urandom_range(0, SLOTS - 1);
			for (int k = SLOTS - 1; k >= 0; k--) begin
				c = (start + k) % SLOTS;
				if (tbl_parent[c] == $signed({1'b0, tbl_cur})) begin
					t = 4'(c);
				end
			end
		end
		return t;
	endfunction

	task automatic send_action(input pst_in_t item, input bit typed, input pst_out_t want);
		int       gap;
		pst_out_t calc;
		gap = (!steady && $urandom_range(0, 99) < 38) ? $urandom_range(1, 3) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		calc = step_table(item);
		due_results.push_back(typed ? want : calc);
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		out_ready <= steady || ($urandom_range(0, 99) >= 38);
	end

	always @(posedge clk) begin : result_check
		pst_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (due_results.size() == 0) begin
				report_mismatch("result with no action outstanding");
			end else begin
				want = due_results.pop_front();
				check_field("running_id", out_data.running_id, want.running_id);
				check_field("switched", out_data.switched, want.switched);
				check_field("reply_valid", out_data.reply_valid, want.reply_valid);
				check_field("reply_value", $signed(out_data.reply_value),
					$signed(want.reply_value));
				check_field("wake_valid", out_data.wake_valid, want.wake_valid);
				check_field("wake_id", out_data.wake_id, want.wake_id);
				check_field("wake_value", out_data.wake_value, want.wake_value);
				check_field("deadlock", out_data.deadlock, want.deadlock);
				if ($isunknown(out_data)) begin
					report_mismatch("unknown bits in result");
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("process_table_scheduler_unit regression: fail");
		$finish;
	end

	initial begin
		pst_in_t item;
		int      roll;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		steady = 1'b0;
		mismatches = 0;
		for (int i = 0; i < SLOTS; i++) begin
			tbl_state[i] = (i == 0) ? ST_READY : ST_TERMINATED;
			tbl_parent[i] = NO_PARENT;
			tbl_awaited[i] = NOT_WAITING;
		end
		tbl_cur = '0;

		// Start-up, bad wait targets, reserved codes, fill the table.
		plan(ACT_GETPID, 4'sd0, 1'b1, plain_out(3'd0, 1'b1, 4'sd0));
		plan(ACT_TICK, 4'sd0, 1'b1, plain_out(3'd0, 1'b0, 4'sd0));
		plan(ACT_WAIT, ANY_CHILD, 1'b1, plain_out(3'd0, 1'b1, REPLY_ERR));
		plan(ACT_WAIT, -4'sd8, 1'b1, plain_out(3'd0, 1'b1, REPLY_ERR));
		plan(ACT_WAIT, 4'sd7, 1'b1, plain_out(3'd0, 1'b1, REPLY_ERR));
		plan(ACT_RSVD_FIRST, 4'sd7, 1'b1, plain_out(3'd0, 1'b0, 4'sd0));
		plan(ACT_RSVD_LAST, -4'sd1, 1'b1, plain_out(3'd0, 1'b0, 4'sd0));
		for (int i = 1; i < SLOTS; i++) begin
			plan(ACT_FORK, 4'sd0, 1'b1, plain_out(3'd0, 1'b1, 4'(i)));
		end
		plan(ACT_FORK, 4'sd0, 1'b1, plain_out(3'd0, 1'b1, REPLY_ERR));
		// Block on a child, wake on its exit, then plain exits down to slot 0.
		plan(ACT_WAIT, 4'sd1, 1'b0, '0);
		for (int i = 1; i < SLOTS; i++) begin
			plan(ACT_EXIT, 4'sd0, 1'b0, '0);
		end
		// Reap zombies, orphan exit into deadlock, recover through fork.
		plan(ACT_WAIT, 4'sd2, 1'b0, '0);
		plan(ACT_WAIT, ANY_CHILD, 1'b0, '0);
		plan(ACT_EXIT, 4'sd0, 1'b0, '0);
		plan(ACT_GETPID, 4'sd0, 1'b0, '0);
		plan(ACT_FORK, 4'sd0, 1'b0, '0);
		plan(ACT_TICK, 4'sd0, 1'b0, '0);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_plan[i]) begin
			send_action(directed_plan[i].item, directed_plan[i].typed, directed_plan[i].want);
		end

		for (int n = 0; n < RANDOM_ACTIONS; n++) begin
			steady = (n >= 700 && n < 1000);
			roll = $urandom_range(0, 99);
			item.wait_target = 4'($urandom_range(0, 15));
			if (roll < 18) begin
				item.action = ACT_TICK;
			end else if (roll < 38) begin
				item.action = ACT_FORK;
			end else if (roll < 55) begin
				item.action = ACT_EXIT;
			end else if (roll < 82) begin
				item.action = ACT_WAIT;
				item.wait_target = pick_target();
			end else if (roll < 94) begin
				item.action = ACT_GETPID;
			end else begin
				item.action = 3'($urandom_range(ACT_RSVD_FIRST, ACT_RSVD_LAST));
			end
			send_action(item, 1'b0, '0);
		end
		in_valid <= 1'b0;
		steady = 1'b0;

		while (due_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0) begin
			$display("process_table_scheduler_unit regression: pass");
		end else begin
			$display("process_table_scheduler_unit regression: fail");
		end
		$finish;
	end

endmodule
